// ----- hw/rtl/sem_pkg.sv -----
package sem_pkg;

   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int CFG_W   = 11;
   localparam int TAG_W   = 10;
   localparam int GRAD_W  = 11;
   localparam int SQ_W    = 22;
   localparam int ROOT_W  = 16;
   localparam int ROOT_STEPS = 8;
   localparam logic [CHAN_W-1:0] SAT_VALUE = 8'd255;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // window selector code for a neighbor outside the frame
   localparam logic [1:0] ZSEL = 2'd3;

   typedef struct packed {
      logic [8:0][PIX_W-1:0] win;
      logic [TAG_W-1:0]      row;
      logic [TAG_W-1:0]      col;
      logic                  last;
   } job_type;

endpackage

// ----- hw/rtl/sem_ifs.sv -----
interface sem_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface sem_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_edge;
   logic [7:0] green_edge;
   logic [7:0] blue_edge;
   logic [9:0] out_row;
   logic [9:0] out_col;
   logic       run_last;
   modport source (output valid, red_edge, green_edge, blue_edge, out_row, out_col,
                   run_last, input ready);
   modport sink (input valid, red_edge, green_edge, blue_edge, out_row, out_col,
                 run_last, output ready);
endinterface

interface sem_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [10:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sem_front.sv -----
module sem_front import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic             clock,
   input  logic             reset,
   sem_req_if.sink          req,
   input  logic [CFG_W-1:0] width_i,
   input  logic [CFG_W-1:0] height_i,
   output logic             job_valid,
   input  logic             job_ready,
   output job_type          job
);

   localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CB-1:0] col_ff, col_in, c_cur, c_ff;
   logic [RB-1:0] row_ff, row_in, r_cur, r_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] prev_rd_ff, prev2_rd_ff;
   logic [PIX_W-1:0] line_prev_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] line_prev2_ff [MAX_WIDTH];
   logic [8:0][PIX_W-1:0] window_ff;
   logic [3:0] pend_ff, pend_in, pend_cur;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic last_row, last_col, accept;
   logic [1:0] pick;
   logic [3:0] pick_mask;
   logic [1:0] rs [3];
   logic [1:0] cs [3];

   always_comb begin
      if (width_i == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_i) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_i);
      end
      if (height_i == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_i) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_i);
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   // position of this pixel, folded after a size change
   always_comb begin
      logic [31:0] rr;
      rr = 32'(row_ff);
      c_cur = col_ff;
      if (32'(col_ff) >= 32'(w_eff)) begin
         c_cur = '0;
         rr = rr + 32'd1;
      end
      if (rr >= 32'(h_eff)) begin
         rr = '0;
      end
      r_cur = RB'(rr);
      last_row = (32'(r_cur) + 32'd1 == 32'(h_eff));
      last_col = (32'(c_cur) + 32'd1 == 32'(w_eff));
      pend_cur[0] = (c_cur != '0) && (r_cur != '0);
      pend_cur[1] = (c_cur != '0) && last_row;
      pend_cur[2] = last_col && (r_cur != '0);
      pend_cur[3] = last_col && last_row;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : RB'(32'(r_cur) + 32'd1);
         end else begin
            col_in = CB'(32'(c_cur) + 32'd1);
            row_in = r_cur;
         end
      end
   end

   always_comb begin
      if (pend_ff[0]) begin
         pick = 2'd0;
      end else if (pend_ff[1]) begin
         pick = 2'd1;
      end else if (pend_ff[2]) begin
         pick = 2'd2;
      end else begin
         pick = 2'd3;
      end
      pick_mask = 4'b0001 << pick;
   end

   always_comb begin
      if (!pick[0]) begin
         rs[0] = (32'(r_ff) >= 32'd2) ? 2'd0 : ZSEL;
         rs[1] = 2'd1;
         rs[2] = 2'd2;
      end else begin
         rs[0] = (r_ff != '0) ? 2'd1 : ZSEL;
         rs[1] = 2'd2;
         rs[2] = ZSEL;
      end
      if (!pick[1]) begin
         cs[0] = (32'(c_ff) >= 32'd2) ? 2'd0 : ZSEL;
         cs[1] = 2'd1;
         cs[2] = 2'd2;
      end else begin
         cs[0] = (c_ff != '0) ? 2'd1 : ZSEL;
         cs[1] = 2'd2;
         cs[2] = ZSEL;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (rs[i] == ZSEL || cs[j] == ZSEL) begin
               job.win[i*3+j] = '0;
            end else begin
               job.win[i*3+j] = window_ff[4'(rs[i]) * 4'd3 + 4'(cs[j])];
            end
         end
      end
      job.row  = pick[0] ? TAG_W'(32'(r_ff)) : TAG_W'(32'(r_ff) - 32'd1);
      job.col  = pick[1] ? TAG_W'(32'(c_ff)) : TAG_W'(32'(c_ff) - 32'd1);
      job.last = ((pend_ff & ~pick_mask) == 4'd0);
   end

   assign job_valid = (state_ff == S_EMIT) && (pend_ff != 4'd0);

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
               pend_in  = pend_cur;
            end
         end
         S_LOAD: begin
            state_in = (pend_ff != 4'd0) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (job_ready) begin
               pend_in = pend_ff & ~pick_mask;
               if ((pend_ff & ~pick_mask) == 4'd0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_ff   <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         window_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (state_ff == S_LOAD) begin
            for (int k = 0; k < 3; k++) begin
               window_ff[k*3+0] <= window_ff[k*3+1];
               window_ff[k*3+1] <= window_ff[k*3+2];
            end
            window_ff[2] <= prev2_rd_ff;
            window_ff[5] <= prev_rd_ff;
            window_ff[8] <= pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff      <= {req.blue_in, req.green_in, req.red_in};
         c_ff        <= c_cur;
         r_ff        <= r_cur;
         prev_rd_ff  <= line_prev_ff[c_cur];
         prev2_rd_ff <= line_prev2_ff[c_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         line_prev_ff[c_ff]  <= pix_ff;
         line_prev2_ff[c_ff] <= prev_rd_ff;
      end
   end

endmodule

// ----- hw/rtl/sem_fifo.sv -----
module sem_fifo import sem_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type    entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/sem_back.sv -----
module sem_back import sem_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   sem_rsp_if.source rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GRAD = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   job_type job_ff;
   logic signed [GRAD_W-1:0] gx_ff [3];
   logic signed [GRAD_W-1:0] gy_ff [3];
   logic [ROOT_W-1:0] val_ff [3];
   logic [ROOT_W-1:0] res_ff [3];
   logic              sat_ff [3];
   logic [2:0]        step_ff;
   logic [ROOT_W-1:0] bit_cur;

   assign job_ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign bit_cur   = ROOT_W'(1) << {3'(ROOT_STEPS - 1) - step_ff, 1'b0};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (job_valid) state_in = S_GRAD;
         S_GRAD: state_in = S_SQ;
         S_SQ:   state_in = S_ROOT;
         S_ROOT: if (step_ff == 3'(ROOT_STEPS - 1)) state_in = S_OUT;
         S_OUT:  if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_ROOT) begin
            step_ff <= step_ff + 3'd1;
         end else begin
            step_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [GRAD_W-1:0] p [9];
      logic [SQ_W-1:0] sq;
      logic [ROOT_W:0] trial;
      if (state_ff == S_IDLE && job_valid) begin
         job_ff <= job;
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 9; k++) begin
            p[k] = GRAD_W'(job_ff.win[k][ch*CHAN_W +: CHAN_W]);
         end
         sq = SQ_W'(gx_ff[ch] * gx_ff[ch]) + SQ_W'(gy_ff[ch] * gy_ff[ch]);
         trial = {1'b0, res_ff[ch]} + {1'b0, bit_cur};
         case (state_ff)
            S_GRAD: begin
               gx_ff[ch] <= GRAD_W'(p[0] - p[2] + 2 * (p[3] - p[5]) + p[6] - p[8]);
               gy_ff[ch] <= GRAD_W'(p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8]);
            end
            S_SQ: begin
               sat_ff[ch] <= (sq >= SQ_W'(65536));
               val_ff[ch] <= ROOT_W'(sq);
               res_ff[ch] <= '0;
            end
            S_ROOT: begin
               if ({1'b0, val_ff[ch]} >= trial) begin
                  val_ff[ch] <= ROOT_W'({1'b0, val_ff[ch]} - trial);
                  res_ff[ch] <= (res_ff[ch] >> 1) + bit_cur;
               end else begin
                  res_ff[ch] <= res_ff[ch] >> 1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp.red_edge   = sat_ff[0] ? SAT_VALUE : res_ff[0][CHAN_W-1:0];
   assign rsp.green_edge = sat_ff[1] ? SAT_VALUE : res_ff[1][CHAN_W-1:0];
   assign rsp.blue_edge  = sat_ff[2] ? SAT_VALUE : res_ff[2][CHAN_W-1:0];
   assign rsp.out_row    = job_ff.row;
   assign rsp.out_col    = job_ff.col;
   assign rsp.run_last   = job_ff.last;

endmodule

// ----- hw/rtl/sobel_edge_magnitude_3x3.sv -----
// Flow: a pixel is registered when taken, its window is built in the next cycle, then its
// results enter a two-entry job queue at one per cycle while the queue has room;
// a pixel with no results goes back to idle once its window is built.
// Each result passes through the magnitude unit (gradients, squares, 8-step
// square root, output), which takes a new result only after the last is output.
// Reset clears counters, window and handshake state; line stores are not cleared.
module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic      clock,
   input  logic      reset,
   sem_req_if.sink   req_chan,
   sem_rsp_if.source rsp_chan,
   sem_csr_if.sink   csr_chan
);

   logic [CFG_W-1:0] width_ff, height_ff;
   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1024);
         height_ff <= CFG_W'(1024);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_FRAME_WIDTH:  width_ff  <= csr_chan.data;
            REG_FRAME_HEIGHT: height_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .req(req_chan), .width_i(width_ff), .height_i(height_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   sem_fifo u_fifo (
      .clock, .reset, .push_valid(fj_valid), .push_ready(fj_ready), .push_data(fj),
      .pop_valid(bj_valid), .pop_ready(bj_ready), .pop_data(bj)
   );

   sem_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .rsp(rsp_chan)
   );

endmodule
